### src/descriptor_free_list_allocator_unit_macros.svh
// assertion helpers for the descriptor free-list allocator
`ifndef DESCRIPTOR_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define DESCRIPTOR_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define DFLAU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define DFLAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/dflau_pkg.sv
`timescale 1ns / 1ps

package dflau_pkg;

    // default pool depth
    localparam int POOL_DEPTH_DEF = 64;

    // field widths
    localparam int HANDLE_W   = 64;
    localparam int STRIDE_W   = 13;
    localparam int SLOTS_W    = 7;
    localparam int IDX_W      = 7;
    localparam int SLOT_OUT_W = 6;
    localparam int CFG_IDX_W  = 2;

    // quotient bits produced per divider cycle
    localparam int DIV_BITS = 4;

    // configuration reset values
    localparam logic [STRIDE_W-1:0] STRIDE_RST = 13'd32;
    localparam logic [SLOTS_W-1:0]  SLOTS_RST  = 7'd64;

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_REFILL = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_RANGE    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CPU_BASE    = 2'd0,
        REG_GPU_BASE    = 2'd1,
        REG_SLOT_STRIDE = 2'd2,
        REG_SLOT_COUNT  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_action               action;
        logic [HANDLE_W-1:0]   cpu_addr;
        logic [HANDLE_W-1:0]   gpu_addr;
    } t_item;

    typedef struct packed {
        logic [HANDLE_W-1:0]   cpu_addr_out;
        logic [HANDLE_W-1:0]   gpu_addr_out;
        logic [SLOT_OUT_W-1:0] slot_index;
        t_status               status;
    } t_result;

endpackage

### src/dflau_ram.sv
`timescale 1ns / 1ps

module dflau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/dflau_div.sv
`timescale 1ns / 1ps

module dflau_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dflau_pkg::HANDLE_W-1:0] i_dividend,
    input  logic [dflau_pkg::STRIDE_W-1:0] i_divisor,
    output logic                          o_done,
    output logic [dflau_pkg::HANDLE_W-1:0] o_quotient
);

    localparam int HW    = dflau_pkg::HANDLE_W;
    localparam int SW    = dflau_pkg::STRIDE_W;
    localparam int STEPS = HW / dflau_pkg::DIV_BITS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SW-1:0]    r_div;
    logic [SW-1:0]    r_rem;
    logic [HW-1:0]    r_quo;
    logic [SW-1:0]    n_rem;
    logic [HW-1:0]    n_quo;

    // restoring division, DIV_BITS quotient bits per cycle
    always_comb begin
        logic [SW:0] v_sh;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < dflau_pkg::DIV_BITS; k++) begin
            v_sh  = {n_rem, n_quo[HW-1]};
            n_quo = {n_quo[HW-2:0], 1'b0};
            if (v_sh >= {1'b0, r_div}) begin
                v_sh     = v_sh - {1'b0, r_div};
                n_quo[0] = 1'b1;
            end
            n_rem = v_sh[SW-1:0];
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### src/descriptor_free_list_allocator_unit.sv
`timescale 1ns / 1ps

// LIFO free-list allocator for descriptor heap slots. Free slot indices sit in a
// stack RAM of POOL_DEPTH entries, with the fill count in a register. A command
// is taken when start is high and busy is low; its single result shows on
// o_result for exactly one cycle with o_done high and cannot be held off, so the
// receiver must take it then. Path from accept to o_done: clear, an allocate
// on an empty pool, a free with zero stride and a refill with zero slots raise
// o_done in the next cycle; allocate passes a stack RAM read, then the
// index-by-stride multiply; free waits on the two 64-bit dividers that retire
// four quotient bits per cycle; refill writes the stack RAM once per live slot,
// one write per cycle. busy stays high until the cycle in which o_done rises.

`include "descriptor_free_list_allocator_unit_macros.svh"

module descriptor_free_list_allocator_unit #(
    parameter int POOL_DEPTH = dflau_pkg::POOL_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  dflau_pkg::t_item                i_item,
    output logic                            o_done,
    output dflau_pkg::t_result              o_result,
    input  logic                            i_cfg_we,
    input  logic [dflau_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dflau_pkg::HANDLE_W-1:0]  i_cfg_data
);

    localparam int HW     = dflau_pkg::HANDLE_W;
    localparam int SW     = dflau_pkg::STRIDE_W;
    localparam int NW     = dflau_pkg::SLOTS_W;
    localparam int IW     = dflau_pkg::IDX_W;
    localparam int OW     = dflau_pkg::SLOT_OUT_W;
    localparam int PW     = IW + SW;
    localparam int AW     = $clog2(POOL_DEPTH);
    localparam int CW     = $clog2(POOL_DEPTH + 1);
    localparam int LW     = (CW > NW) ? CW : NW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ARD  = 5'b00010,
        S_AMUL = 5'b00100,
        S_DIV  = 5'b01000,
        S_FILL = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [HW-1:0]       r_cpu_base, r_gpu_base;
    logic [SW-1:0]       r_stride;
    logic [NW-1:0]       r_slots;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_fill, n_fill;
    logic [CW-1:0]       r_live, n_live;
    logic [OW-1:0]       r_idx;
    logic [PW-1:0]       r_prod;
    logic                r_done, n_done;
    dflau_pkg::t_result  r_result, n_result;

    logic [LW-1:0]       live_lw;
    logic [IW-1:0]       live_idx;
    logic [CW-1:0]       live_cnt;
    logic                pool_full;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [IW-1:0]       ram_wdata, ram_rdata;

    logic                div_start;
    logic [HW-1:0]       cpu_dividend, gpu_dividend;
    logic                cdiv_done, gdiv_done;
    logic [HW-1:0]       cpu_quo, gpu_quo;
    logic                quo_mismatch, quo_range;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_base <= '0;
            r_gpu_base <= '0;
            r_stride   <= dflau_pkg::STRIDE_RST;
            r_slots    <= dflau_pkg::SLOTS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dflau_pkg::REG_CPU_BASE:    r_cpu_base <= i_cfg_data;
                dflau_pkg::REG_GPU_BASE:    r_gpu_base <= i_cfg_data;
                dflau_pkg::REG_SLOT_STRIDE: r_stride   <= i_cfg_data[SW-1:0];
                dflau_pkg::REG_SLOT_COUNT:  r_slots    <= i_cfg_data[NW-1:0];
                default: ;
            endcase
        end
    end

    // live slot count, min of slot count and pool depth
    assign live_lw   = (LW'(r_slots) > LW'(POOL_DEPTH)) ? LW'(POOL_DEPTH) : LW'(r_slots);
    assign live_idx  = IW'(live_lw);
    assign live_cnt  = CW'(live_lw);
    assign pool_full = (r_count == CW'(POOL_DEPTH));

    // free stack memory
    dflau_ram #(
        .WIDTH (IW),
        .DEPTH (POOL_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // handle-to-index dividers
    assign cpu_dividend = i_item.cpu_addr - r_cpu_base;
    assign gpu_dividend = i_item.gpu_addr - r_gpu_base;

    dflau_div u_cpu_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (cpu_dividend),
        .i_divisor  (r_stride),
        .o_done     (cdiv_done),
        .o_quotient (cpu_quo)
    );

    dflau_div u_gpu_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (gpu_dividend),
        .i_divisor  (r_stride),
        .o_done     (gdiv_done),
        .o_quotient (gpu_quo)
    );

    // free checks on the finished quotients
    assign quo_mismatch = (cpu_quo != gpu_quo);
    assign quo_range    = (|cpu_quo[HW-1:IW]) || (cpu_quo[IW-1:0] >= live_idx);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_fill    = r_fill;
        n_live    = r_live;
        n_done    = 1'b0;
        n_result  = '0;
        ram_we    = 1'b0;
        ram_waddr = AW'(r_count);
        ram_wdata = cpu_quo[IW-1:0];
        ram_re    = 1'b0;
        ram_raddr = AW'(r_count - CW'(1));
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_item.action)
                        dflau_pkg::ACT_ALLOC: begin
                            if (r_count == '0) begin
                                n_done          = 1'b1;
                                n_result.status = dflau_pkg::ST_EMPTY;
                            end else begin
                                ram_re  = 1'b1;
                                n_count = r_count - CW'(1);
                                n_state = S_ARD;
                            end
                        end
                        dflau_pkg::ACT_FREE: begin
                            if (r_stride == '0) begin
                                n_done          = 1'b1;
                                n_result.status = dflau_pkg::ST_RANGE;
                            end else begin
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        dflau_pkg::ACT_REFILL: begin
                            if (live_cnt == '0) begin
                                n_count = '0;
                                n_done  = 1'b1;
                            end else begin
                                n_live  = live_cnt;
                                n_fill  = '0;
                                n_state = S_FILL;
                            end
                        end
                        dflau_pkg::ACT_CLEAR: begin
                            n_count = '0;
                            n_done  = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_ARD: begin
                n_state = S_AMUL;
            end
            S_AMUL: begin
                n_done                = 1'b1;
                n_result.cpu_addr_out = r_cpu_base + HW'(r_prod);
                n_result.gpu_addr_out = r_gpu_base + HW'(r_prod);
                n_result.slot_index   = r_idx;
                n_result.status       = dflau_pkg::ST_OK;
                n_state               = S_IDLE;
            end
            S_DIV: begin
                if (cdiv_done) begin
                    n_done              = 1'b1;
                    n_result.slot_index = cpu_quo[OW-1:0];
                    if (quo_mismatch) begin
                        n_result.status = dflau_pkg::ST_MISMATCH;
                    end else if (quo_range) begin
                        n_result.status = dflau_pkg::ST_RANGE;
                    end else if (pool_full) begin
                        n_result.status = dflau_pkg::ST_FULL;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            S_FILL: begin
                // entry i gets n-1-i so slot 0 ends on top
                ram_we    = 1'b1;
                ram_waddr = AW'(r_fill);
                ram_wdata = IW'(r_live - r_fill - CW'(1));
                n_fill    = r_fill + CW'(1);
                if (r_fill == r_live - CW'(1)) begin
                    n_count = r_live;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_fill   <= n_fill;
        r_live   <= n_live;
        r_result <= n_result;
        if (r_state == S_ARD) begin
            r_idx  <= ram_rdata[OW-1:0];
            r_prod <= PW'(ram_rdata) * PW'(r_stride);
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // the result transfer always lands with the sequencer back at rest
    `DFLAU_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_done, (r_state == S_IDLE) && !busy, "result strobe while sequencer busy")
    // stack fill never passes the pool depth
    `DFLAU_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(POOL_DEPTH), "free count beyond pool depth")
    // allocate on an empty pool answers at once
    `DFLAU_ASSERT_NEXT(a_empty_alloc, i_clk, i_rst_n, start && !busy && (i_item.action == dflau_pkg::ACT_ALLOC) && (r_count == '0), o_done && (o_result.status == dflau_pkg::ST_EMPTY), "empty allocate not answered")
    // the two dividers always finish together
    `DFLAU_ASSERT_NOW(a_div_lock, i_clk, i_rst_n, cdiv_done || gdiv_done, cdiv_done && gdiv_done, "dividers out of step")

endmodule
